FILE: hdl/cigp_pkg.sv
`default_nettype none

package cigp_pkg;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // Characters of the CIGAR alphabet.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_H    = 8'h48;

  // Result kinds.
  localparam logic KIND_TOKEN   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    OP_M = 3'd0,
    OP_D = 3'd1,
    OP_I = 3'd2,
    OP_S = 3'd3,
    OP_N = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LEADZERO = 3'd1,
    ST_NOCOUNT  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  ch;
    logic [30:0] position;
    logic [31:0] read_length;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    op_t         op_code;
    logic [31:0] op_count;
    logic [30:0] ref_start;
    logic [31:0] ref_end;
    logic [31:0] aligned_length;
    logic [31:0] deletion_length;
    logic [31:0] skipped_length;
    logic [31:0] query_length;
    status_t     status;
    logic        bad_char_seen;
  } result_t;

  typedef struct packed {
    logic hit;
    op_t  op;
  } letter_t;

  // Decode an operation letter that emits a token.
  function automatic letter_t decode_letter(input logic [7:0] c);
    letter_t r;
    r.hit = 1'b1;
    r.op  = OP_M;
    unique case (c)
      CH_M: r.op = OP_M;
      CH_D: r.op = OP_D;
      CH_I: r.op = OP_I;
      CH_S: r.op = OP_S;
      CH_N: r.op = OP_N;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cigp_in_stage.sv
`default_nettype none

module cigp_in_stage
  import cigp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_ch,
  input  wire logic [30:0] in_position,
  input  wire logic [31:0] in_read_length,
  input  wire logic        advance,
  output logic             s1_valid,
  output item_t            s1_item
);

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;

  // The register is free when empty or when its item moves on this cycle.
  assign in_stall     = s1_valid_r && !advance;
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload capture on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r.action      <= in_action;
      s1_item_r.ch          <= in_ch;
      s1_item_r.position    <= in_position;
      s1_item_r.read_length <= in_read_length;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

FILE: hdl/cigp_core.sv
`default_nettype none

module cigp_core
  import cigp_pkg::*;
#(
  parameter int LENGTH_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  output logic       res_valid,
  output result_t    res
);

  localparam int LW  = LENGTH_WIDTH;
  localparam int AW  = LW + 4;
  localparam int SW  = LW + 2;
  localparam int MW  = (LW > 32) ? LW : 32;
  localparam int EW  = ((SW > 31) ? SW : 31) + 1;
  localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};
  localparam logic [EW-1:0] END_MAX = EW'({32{1'b1}});

  // Record state.
  logic [LW-1:0] acc_r, acc_nxt;
  logic          present_r, present_nxt;
  status_t       err_r, err_nxt;
  logic [LW-1:0] aligned_r, aligned_nxt;
  logic [LW-1:0] deleted_r, deleted_nxt;
  logic [LW-1:0] skipped_r, skipped_nxt;
  logic [LW-1:0] query_r, query_nxt;
  logic [30:0]   start_r, start_nxt;
  logic [31:0]   expect_r, expect_nxt;
  logic          warn_r, warn_nxt;
  logic          seen_r, seen_nxt;

  // Shared arithmetic on the current state.
  logic [AW-1:0] acc_x10;
  logic          acc_ovf;
  logic          is_digit;
  letter_t       letter;
  logic [LW:0]   add_aligned, add_deleted, add_skipped, add_query;
  logic [SW-1:0] span;
  logic [EW-1:0] end_pos;
  logic [MW-1:0] ext_acc, ext_aligned, ext_deleted, ext_skipped, ext_query, ext_expect;
  status_t       end_status;

  assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign letter   = decode_letter(item.ch);

  // Count times ten plus the new digit, as shifts and adds.
  assign acc_x10 = AW'({acc_r, 3'b000}) + AW'({acc_r, 1'b0}) + AW'(item.ch[3:0]);
  assign acc_ovf = |acc_x10[AW-1:LW];

  assign add_aligned = {1'b0, aligned_r} + {1'b0, acc_r};
  assign add_deleted = {1'b0, deleted_r} + {1'b0, acc_r};
  assign add_skipped = {1'b0, skipped_r} + {1'b0, acc_r};
  assign add_query   = {1'b0, query_r} + {1'b0, acc_r};

  // Reference span of the summary.
  assign span    = SW'(aligned_r) + SW'(deleted_r) + SW'(skipped_r);
  assign end_pos = (span != '0) ? (EW'(start_r) + EW'(span) - EW'(1)) : EW'(start_r);

  assign ext_acc     = MW'(acc_r);
  assign ext_aligned = MW'(aligned_r);
  assign ext_deleted = MW'(deleted_r);
  assign ext_skipped = MW'(skipped_r);
  assign ext_query   = MW'(query_r);
  assign ext_expect  = MW'(expect_r);

  always_comb begin
    if (err_r == ST_OK && !seen_r) begin
      end_status = ST_EMPTY;
    end else if (err_r == ST_OK && ext_query != ext_expect) begin
      end_status = ST_MISMATCH;
    end else begin
      end_status = err_r;
    end
  end

  // Next state and result for the item in the input register.
  always_comb begin
    acc_nxt     = acc_r;
    present_nxt = present_r;
    err_nxt     = err_r;
    aligned_nxt = aligned_r;
    deleted_nxt = deleted_r;
    skipped_nxt = skipped_r;
    query_nxt   = query_r;
    start_nxt   = start_r;
    expect_nxt  = expect_r;
    warn_nxt    = warn_r;
    seen_nxt    = seen_r;
    res_valid   = 1'b0;
    res         = '0;
    res.op_code = OP_M;
    res.status  = ST_OK;
    if (fire) begin
      unique case (item.action)
        ACT_START: begin
          acc_nxt     = '0;
          present_nxt = 1'b0;
          err_nxt     = ST_OK;
          aligned_nxt = '0;
          deleted_nxt = '0;
          skipped_nxt = '0;
          query_nxt   = '0;
          warn_nxt    = 1'b0;
          seen_nxt    = 1'b0;
          start_nxt   = item.position;
          expect_nxt  = item.read_length;
        end
        ACT_CHAR: begin
          if (err_r == ST_OK) begin
            seen_nxt = 1'b1;
            if (is_digit) begin
              if (item.ch == CH_ZERO && !present_r) begin
                err_nxt = ST_LEADZERO;
              end else if (acc_ovf) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                acc_nxt     = acc_x10[LW-1:0];
                present_nxt = 1'b1;
              end
            end else if (item.ch == CH_H) begin
              acc_nxt     = '0;
              present_nxt = 1'b0;
            end else if (!letter.hit) begin
              warn_nxt    = 1'b1;
              acc_nxt     = '0;
              present_nxt = 1'b0;
            end else if (!present_r) begin
              err_nxt = ST_NOCOUNT;
            end else begin
              acc_nxt      = '0;
              present_nxt  = 1'b0;
              res_valid    = 1'b1;
              res.kind     = KIND_TOKEN;
              res.op_code  = letter.op;
              res.op_count = ext_acc[31:0];
              // Saturating updates of the sums this letter feeds.
              case (letter.op)
                OP_M: begin
                  aligned_nxt = add_aligned[LW] ? LEN_MAX : add_aligned[LW-1:0];
                  query_nxt   = add_query[LW] ? LEN_MAX : add_query[LW-1:0];
                  if (add_aligned[LW] || add_query[LW]) begin
                    err_nxt = ST_OVERFLOW;
                  end
                end
                OP_D: begin
                  deleted_nxt = add_deleted[LW] ? LEN_MAX : add_deleted[LW-1:0];
                  if (add_deleted[LW]) begin
                    err_nxt = ST_OVERFLOW;
                  end
                end
                OP_N: begin
                  skipped_nxt = add_skipped[LW] ? LEN_MAX : add_skipped[LW-1:0];
                  if (add_skipped[LW]) begin
                    err_nxt = ST_OVERFLOW;
                  end
                end
                default: begin
                  query_nxt = add_query[LW] ? LEN_MAX : add_query[LW-1:0];
                  if (add_query[LW]) begin
                    err_nxt = ST_OVERFLOW;
                  end
                end
              endcase
            end
          end
        end
        ACT_END: begin
          res_valid           = 1'b1;
          res.kind            = KIND_SUMMARY;
          res.ref_start       = start_r;
          res.ref_end         = (end_pos > END_MAX) ? 32'hFFFF_FFFF : end_pos[31:0];
          res.aligned_length  = ext_aligned[31:0];
          res.deletion_length = ext_deleted[31:0];
          res.skipped_length  = ext_skipped[31:0];
          res.query_length    = ext_query[31:0];
          res.status          = end_status;
          res.bad_char_seen   = warn_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      present_r <= 1'b0;
      err_r     <= ST_OK;
      aligned_r <= '0;
      deleted_r <= '0;
      skipped_r <= '0;
      query_r   <= '0;
      start_r   <= '0;
      expect_r  <= '0;
      warn_r    <= 1'b0;
      seen_r    <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      present_r <= present_nxt;
      err_r     <= err_nxt;
      aligned_r <= aligned_nxt;
      deleted_r <= deleted_nxt;
      skipped_r <= skipped_nxt;
      query_r   <= query_nxt;
      start_r   <= start_nxt;
      expect_r  <= expect_nxt;
      warn_r    <= warn_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cigp_out_stage.sv
`default_nettype none

module cigp_out_stage
  import cigp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    s1_valid,
  input  wire logic    res_valid,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         advance,
  output logic         out_valid,
  output result_t      out_res
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  // The result register takes a new item when empty or being drained.
  assign advance       = !out_valid_r || !out_stall;
  assign out_valid_nxt = advance ? (s1_valid && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

FILE: hdl/cigar_string_parser.sv
// CIGAR text parser.
// Input channel (in_valid / in_stall): one item per accepted cycle. A start
// item loads the mapping position and read length and clears the record; a
// character item carries one CIGAR character; an end item asks for the
// record summary. Output channel (out_valid / out_stall): an operation token
// for each M, D, I, S or N letter that closes a count, and one summary per
// end item. Other items give no result.
// Throughput is one item per cycle while out_stall is low. An accepted item
// waits in the input register, then goes through the single pass of parsing
// logic into the result register. The running sums and the pending count
// update in that same pass, so the next item sees them at once.
// When the receiver holds out_stall, the result register keeps its item,
// the input register fills, and in_stall rises in the same cycle that the
// input register cannot pass its item on.
// Synchronous reset clears both registers' valid flags and all record state,
// as if an empty record had started at position zero with read length zero.
`default_nettype none

module cigar_string_parser
  import cigp_pkg::*;
#(
  parameter int LENGTH_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_ch,
  input  wire logic [30:0] in_position,
  input  wire logic [31:0] in_read_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [2:0]       out_op_code,
  output logic [31:0]      out_op_count,
  output logic [30:0]      out_ref_start,
  output logic [31:0]      out_ref_end,
  output logic [31:0]      out_aligned_length,
  output logic [31:0]      out_deletion_length,
  output logic [31:0]      out_skipped_length,
  output logic [31:0]      out_query_length,
  output logic [2:0]       out_status,
  output logic             out_bad_char_seen
);

  logic    advance;
  logic    s1_valid;
  item_t   s1_item;
  logic    res_valid;
  result_t res;
  result_t out_res;

  cigp_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_ch          (in_ch),
    .in_position    (in_position),
    .in_read_length (in_read_length),
    .advance        (advance),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item)
  );

  cigp_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_valid && advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  cigp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Result fields onto their ports.
  assign out_kind            = out_res.kind;
  assign out_op_code         = out_res.op_code;
  assign out_op_count        = out_res.op_count;
  assign out_ref_start       = out_res.ref_start;
  assign out_ref_end         = out_res.ref_end;
  assign out_aligned_length  = out_res.aligned_length;
  assign out_deletion_length = out_res.deletion_length;
  assign out_skipped_length  = out_res.skipped_length;
  assign out_query_length    = out_res.query_length;
  assign out_status          = out_res.status;
  assign out_bad_char_seen   = out_res.bad_char_seen;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cigp_pkg::*;

  localparam int LEN_W = 32;
  localparam logic [63:0] LEN_MAX = (64'd1 << LEN_W) - 64'd1;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Clock, reset and the two channels.
  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_NONE;
  logic [7:0] in_ch = 8'd0;
  logic [30:0] in_position = 31'd0;
  logic [31:0] in_read_length = 32'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic [2:0] out_op_code;
  logic [31:0] out_op_count;
  logic [30:0] out_ref_start;
  logic [31:0] out_ref_end;
  logic [31:0] out_aligned_length;
  logic [31:0] out_deletion_length;
  logic [31:0] out_skipped_length;
  logic [31:0] out_query_length;
  logic [2:0] out_status;
  logic out_bad_char_seen;

  // Record state of the parser as the testbench sees it.
  logic [63:0] pend_count;
  bit pend_valid;
  status_t rec_status;
  logic [63:0] tot_aligned;
  logic [63:0] tot_deleted;
  logic [63:0] tot_skipped;
  logic [63:0] tot_query;
  logic [30:0] rec_start;
  logic [31:0] rec_readlen;
  bit rec_warn;
  bit rec_touched;

  result_t results_due[$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  // One row of the directed table.
  typedef struct {
    item_t stim;
    bit typed;
    result_t want;
  } plan_row_t;

  plan_row_t plan_q[$];

  cigar_string_parser #(.LENGTH_WIDTH(LEN_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_ch(in_ch),
    .in_position(in_position),
    .in_read_length(in_read_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_op_code(out_op_code),
    .out_op_count(out_op_count),
    .out_ref_start(out_ref_start),
    .out_ref_end(out_ref_end),
    .out_aligned_length(out_aligned_length),
    .out_deletion_length(out_deletion_length),
    .out_skipped_length(out_skipped_length),
    .out_query_length(out_query_length),
    .out_status(out_status),
    .out_bad_char_seen(out_bad_char_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clears everything that a start item clears but the position and read length.
  function automatic void clear_record();
    pend_count = '0;
    pend_valid = 1'b0;
    rec_status = ST_OK;
    tot_aligned = '0;
    tot_deleted = '0;
    tot_skipped = '0;
    tot_query = '0;
    rec_warn = 1'b0;
    rec_touched = 1'b0;
  endfunction

  // Saturating sum; going past the ceiling flags an overflow.
  function automatic logic [63:0] sat_sum(input logic [63:0] acc, input logic [63:0] v);
    logic [63:0] s;
    s = acc + v;
    if (s > LEN_MAX) begin
      s = LEN_MAX;
      rec_status = ST_OVERFLOW;
    end
    return s;
  endfunction

  // Advances the record state by one item and returns 1 when it yields a result.
  function automatic bit parse_cigar_item(input item_t it, output result_t res);
    logic [63:0] nxt;
    logic [63:0] n;
    logic [63:0] span;
    logic [63:0] fin;
    bit is_op;
    op_t op;
    status_t st;
    res = '0;
    is_op = 1'b1;
    op = OP_M;
    case (it.action)
      ACT_START: begin
        clear_record();
        rec_start = it.position;
        rec_readlen = it.read_length;
        return 1'b0;
      end
      ACT_CHAR: begin
        // A latched error freezes the record until the next start.
        if (rec_status != ST_OK) return 1'b0;
        rec_touched = 1'b1;
        if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
          if (it.ch == CH_ZERO && !pend_valid) begin
            rec_status = ST_LEADZERO;
            return 1'b0;
          end
          nxt = pend_count * 64'd10 + 64'(it.ch - CH_ZERO);
          if (nxt > LEN_MAX) begin
            rec_status = ST_OVERFLOW;
            return 1'b0;
          end
          pend_count = nxt;
          pend_valid = 1'b1;
          return 1'b0;
        end
        if (it.ch == CH_H) begin
          pend_count = '0;
          pend_valid = 1'b0;
          return 1'b0;
        end
        case (it.ch)
          CH_M: op = OP_M;
          CH_D: op = OP_D;
          CH_I: op = OP_I;
          CH_S: op = OP_S;
          CH_N: op = OP_N;
          default: is_op = 1'b0;
        endcase
        if (!is_op) begin
          rec_warn = 1'b1;
          pend_count = '0;
          pend_valid = 1'b0;
          return 1'b0;
        end
        if (!pend_valid) begin
          rec_status = ST_NOCOUNT;
          return 1'b0;
        end
        n = pend_count;
        pend_count = '0;
        pend_valid = 1'b0;
        case (op)
          OP_M: begin
            tot_aligned = sat_sum(tot_aligned, n);
            tot_query = sat_sum(tot_query, n);
          end
          OP_D: tot_deleted = sat_sum(tot_deleted, n);
          OP_I, OP_S: tot_query = sat_sum(tot_query, n);
          default: tot_skipped = sat_sum(tot_skipped, n);
        endcase
        res.kind = KIND_TOKEN;
        res.op_code = op;
        res.op_count = n[31:0];
        return 1'b1;
      end
      ACT_END: begin
        st = rec_status;
        if (st == ST_OK && !rec_touched) st = ST_EMPTY;
        else if (st == ST_OK && tot_query != {32'd0, rec_readlen}) st = ST_MISMATCH;
        span = tot_aligned + tot_deleted + tot_skipped;
        fin = {33'd0, rec_start};
        if (span != 0) fin = {33'd0, rec_start} + span - 64'd1;
        if (fin > 64'hFFFF_FFFF) fin = 64'hFFFF_FFFF;
        res.kind = KIND_SUMMARY;
        res.ref_start = rec_start;
        res.ref_end = fin[31:0];
        res.aligned_length = tot_aligned[31:0];
        res.deletion_length = tot_deleted[31:0];
        res.skipped_length = tot_skipped[31:0];
        res.query_length = tot_query[31:0];
        res.status = st;
        res.bad_char_seen = rec_warn;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t make_item(input logic [1:0] a, input logic [7:0] c,
                                      input logic [30:0] p, input logic [31:0] rl);
    item_t it;
    it.action = a;
    it.ch = c;
    it.position = p;
    it.read_length = rl;
    return it;
  endfunction

  function automatic void plan_add(input logic [1:0] a, input logic [7:0] c,
                                   input logic [30:0] p, input logic [31:0] rl);
    plan_row_t row;
    row.stim = make_item(a, c, p, rl);
    row.typed = 1'b0;
    row.want = '0;
    plan_q.push_back(row);
  endfunction

  // Attaches a hand-written expectation to the last row of the table.
  function automatic void plan_expect(input result_t want);
    plan_q[plan_q.size() - 1].typed = 1'b1;
    plan_q[plan_q.size() - 1].want = want;
  endfunction

  // Offers one item, with random gaps, and books its result once accepted.
  task automatic send_item(input item_t it, input bit use_typed, input result_t typed_want);
    result_t res;
    bit has_res;
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_ch <= it.ch;
    in_position <= it.position;
    in_read_length <= it.read_length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_res = parse_cigar_item(it, res);
    if (has_res) results_due.push_back(use_typed ? typed_want : res);
    if (it.action != ACT_NONE) items_sent++;
  endtask

  function automatic bit field_differs(input string fname, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got === want) return 1'b0;
    if (mismatches < 10)
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
    return 1'b1;
  endfunction

  // Compares one accepted result with the oldest outstanding one.
  task automatic check_result();
    result_t want;
    bit bad;
    if (results_due.size() == 0) begin
      if (mismatches < 10) $display("%0t: result item arrived with none outstanding", $time);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    bad = 1'b0;
    bad |= field_differs("kind", 64'(want.kind), 64'(out_kind));
    bad |= field_differs("op_code", 64'(want.op_code), 64'(out_op_code));
    bad |= field_differs("op_count", 64'(want.op_count), 64'(out_op_count));
    bad |= field_differs("ref_start", 64'(want.ref_start), 64'(out_ref_start));
    bad |= field_differs("ref_end", 64'(want.ref_end), 64'(out_ref_end));
    bad |= field_differs("aligned_length", 64'(want.aligned_length),
                         64'(out_aligned_length));
    bad |= field_differs("deletion_length", 64'(want.deletion_length),
                         64'(out_deletion_length));
    bad |= field_differs("skipped_length", 64'(want.skipped_length),
                         64'(out_skipped_length));
    bad |= field_differs("query_length", 64'(want.query_length), 64'(out_query_length));
    bad |= field_differs("status", 64'(want.status), 64'(out_status));
    bad |= field_differs("bad_char_seen", 64'(want.bad_char_seen), 64'(out_bad_char_seen));
    if (bad) mismatches++;
  endtask

  // Result side: check accepted items and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    out_stall <= !calm && ($urandom_range(99) < 23);
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cigar_string_parser verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    result_t r;
    item_t it;
    logic [7:0] char_q[$];
    logic [7:0] letter;
    logic [63:0] cnt;
    logic [63:0] qsum;
    logic [31:0] rl;
    logic [30:0] pos;
    string digits;
    string biggest;
    int nops;
    int flaw;
    int roll;
    bit drained_once;
    drained_once = 1'b0;
    biggest = "4294967295";
    clear_record();
    rec_start = '0;
    rec_readlen = '0;

    // Directed table.
    // A stray end straight after reset reports an empty record at zero.
    plan_add(ACT_END, 8'd0, 31'd0, 32'd0);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.status = ST_EMPTY;
    plan_expect(r);
    // Largest position, read length and count, ending at the clamped ceiling.
    plan_add(ACT_START, 8'd0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < biggest.len(); k++) plan_add(ACT_CHAR, biggest[k], 31'd0, 32'd0);
    plan_add(ACT_CHAR, CH_M, 31'd0, 32'd0);
    r = '0;
    r.kind = KIND_TOKEN;
    r.op_code = OP_M;
    r.op_count = 32'hFFFF_FFFF;
    plan_expect(r);
    plan_add(ACT_END, 8'd0, 31'd0, 32'd0);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.ref_start = 31'h7FFF_FFFF;
    r.ref_end = 32'hFFFF_FFFF;
    r.aligned_length = 32'hFFFF_FFFF;
    r.query_length = 32'hFFFF_FFFF;
    r.status = ST_OK;
    plan_expect(r);
    // Every other operation, then an unknown character and a letter without a count.
    plan_add(ACT_START, 8'd0, 31'd5, 32'd9);
    plan_add(ACT_CHAR, "2", 31'd0, 32'd0);
    plan_add(ACT_CHAR, CH_D, 31'd0, 32'd0);
    plan_add(ACT_CHAR, "3", 31'd0, 32'd0);
    plan_add(ACT_CHAR, CH_I, 31'd0, 32'd0);
    plan_add(ACT_CHAR, "4", 31'd0, 32'd0);
    plan_add(ACT_CHAR, CH_S, 31'd0, 32'd0);
    plan_add(ACT_CHAR, "1", 31'd0, 32'd0);
    plan_add(ACT_CHAR, CH_N, 31'd0, 32'd0);
    plan_add(ACT_CHAR, "%", 31'd0, 32'd0);
    plan_add(ACT_CHAR, CH_N, 31'd0, 32'd0);
    plan_add(ACT_END, 8'd0, 31'd0, 32'd0);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.ref_start = 31'd5;
    r.ref_end = 32'd7;
    r.deletion_length = 32'd2;
    r.skipped_length = 32'd1;
    r.query_length = 32'd7;
    r.status = ST_NOCOUNT;
    r.bad_char_seen = 1'b1;
    plan_expect(r);
    // The unused action code is ignored.
    plan_add(ACT_NONE, 8'hFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) send_item(plan_q[i].stim, plan_q[i].typed, plan_q[i].want);

    // Random records, mostly well formed, with noise and flaws mixed in.
    items_sent = 0;
    r = '0;
    while (items_sent < RANDOM_ITEMS) begin
      calm = (items_sent >= 150 && items_sent < 270);
      roll = $urandom_range(99);
      if (roll < 8) begin
        // Noise: stray items of any action and any character.
        repeat ($urandom_range(1, 4)) begin
          it = make_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                         31'($urandom), $urandom);
          send_item(it, 1'b0, r);
        end
      end else begin
        char_q.delete();
        qsum = '0;
        nops = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < nops; k++) begin
          case ($urandom_range(11))
            0, 1, 2, 3: letter = CH_M;
            4, 5: letter = CH_D;
            6, 7: letter = CH_I;
            8, 9: letter = CH_S;
            10: letter = CH_N;
            default: letter = CH_H;
          endcase
          roll = $urandom_range(99);
          if (roll < 70) cnt = 64'($urandom_range(1, 999));
          else if (roll < 85) cnt = 64'($urandom_range(1000, 10_000_000));
          else if (roll < 92) cnt = 64'($urandom_range(1, 32'hFFFF_FFFF));
          else if (roll < 97) cnt = LEN_MAX;
          else cnt = LEN_MAX + 64'($urandom_range(1, 1000));
          digits = $sformatf("%0d", cnt);
          if (letter == CH_M || letter == CH_I || letter == CH_S) qsum += cnt;
          flaw = $urandom_range(99);
          if (flaw < 3) char_q.push_back(CH_ZERO);
          if (flaw < 3 || flaw >= 6)
            for (int j = 0; j < digits.len(); j++) char_q.push_back(digits[j]);
          if (flaw >= 6 && flaw < 9) char_q.push_back(8'($urandom_range(255)));
          char_q.push_back(letter);
        end
        // A count left open at the end is dropped.
        if ($urandom_range(99) < 5) begin
          digits = $sformatf("%0d", $urandom_range(1, 99));
          for (int j = 0; j < digits.len(); j++) char_q.push_back(digits[j]);
        end
        roll = $urandom_range(99);
        pos = (roll < 5) ? 31'd0 : (roll < 10) ? 31'h7FFF_FFFF : 31'($urandom);
        rl = ($urandom_range(99) < 65) ? qsum[31:0] : $urandom;
        send_item(make_item(ACT_START, 8'($urandom_range(255)), pos, rl), 1'b0, r);
        foreach (char_q[j])
          send_item(make_item(ACT_CHAR, char_q[j], 31'($urandom), $urandom), 1'b0, r);
        if ($urandom_range(99) >= 5)
          send_item(make_item(ACT_END, 8'($urandom_range(255)), 31'($urandom), $urandom),
                    1'b0, r);
      end
      // Let the pipe run dry before carrying on.
      if ((!drained_once && items_sent >= 350) || $urandom_range(99) < 2) begin
        drained_once = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
      end
    end

    // Drain the outstanding results, then allow for the pipeline depth.
    calm = 1'b0;
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("cigar_string_parser verification clean");
    end else begin
      $display("cigar_string_parser verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/cigp_pkg.sv
hdl/cigp_in_stage.sv
hdl/cigp_core.sv
hdl/cigp_out_stage.sv
hdl/cigar_string_parser.sv
test/tb_top.sv
